[sv/lcbf_pkg.sv]
// ----------------------------------------------------------------------------
// lcbf_pkg
// Shared types and codes for the line counting byte FIFO.
// ----------------------------------------------------------------------------
package lcbf_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int BYTE_W    = 8;
  localparam int HELD_W    = 7;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [HELD_W-1:0] held_t;
  typedef logic [1:0]        op_t;
  typedef logic [1:0]        status_t;

  localparam byte_t NEWLINE = 8'h0A;

  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_LINE = 2'd2;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_NOLINE = 2'd3;

endpackage

[sv/lcbf_mem.sv]
// ----------------------------------------------------------------------------
// lcbf_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lcbf_mem
  import lcbf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  byte_t                    wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output byte_t                    rd_data
);

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/lcbf_ctrl.sv]
// ----------------------------------------------------------------------------
// lcbf_ctrl
// Pointers, counts, operation sequencer and result register.
// ----------------------------------------------------------------------------
module lcbf_ctrl
  import lcbf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  op_t                      in_operation,
  input  byte_t                    in_data_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output byte_t                    out_out_byte,
  output logic                     out_byte_valid,
  output logic                     out_last,
  output status_t                  out_status,
  output held_t                    out_bytes_held,
  output held_t                    out_lines_held,
  output logic                     mem_wr_en,
  output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
  output byte_t                    mem_wr_data,
  output logic                     mem_rd_en,
  output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
  input  byte_t                    mem_rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_LINE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lines_r, lines_nxt;

  logic    out_valid_r, out_valid_nxt;
  byte_t   byte_r, byte_nxt;
  logic    bvalid_r, bvalid_nxt;
  logic    last_r, last_nxt;
  status_t status_r, status_nxt;
  held_t   bheld_r, bheld_nxt;
  held_t   lheld_r, lheld_nxt;

  logic          out_free;
  logic          accept;
  logic          rd_nl;
  logic [AW-1:0] rptr_adv;
  logic [AW-1:0] wptr_adv;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign rd_nl    = (mem_rd_data == NEWLINE);
  assign rptr_adv = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
  assign wptr_adv = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;

  assign mem_wr_addr = wptr_r;
  assign mem_wr_data = in_data_byte;

  always_comb begin
    state_nxt     = state_r;
    rptr_nxt      = rptr_r;
    wptr_nxt      = wptr_r;
    cnt_nxt       = cnt_r;
    lines_nxt     = lines_r;
    out_valid_nxt = out_valid_r && out_stall;
    byte_nxt      = byte_r;
    bvalid_nxt    = bvalid_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    bheld_nxt     = bheld_r;
    lheld_nxt     = lheld_r;
    mem_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = rptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          byte_nxt   = '0;
          bvalid_nxt = 1'b0;
          last_nxt   = 1'b1;
          bheld_nxt  = held_t'(cnt_r);
          lheld_nxt  = held_t'(lines_r);
          case (in_operation)
            OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_wr_en  = 1'b1;
                wptr_nxt   = wptr_adv;
                cnt_nxt    = cnt_r + 1'b1;
                lines_nxt  = lines_r + CW'(in_data_byte == NEWLINE);
                status_nxt = ST_OK;
                bheld_nxt  = held_t'(cnt_nxt);
                lheld_nxt  = held_t'(lines_nxt);
              end
            end
            OP_POP: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_EMPTY;
              end else begin
                mem_rd_en = 1'b1;
                state_nxt = S_POP;
              end
            end
            OP_LINE: begin
              if (lines_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_NOLINE;
              end else begin
                mem_rd_en = 1'b1;
                state_nxt = S_LINE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP, S_LINE: begin
        if (out_free) begin
          rptr_nxt      = rptr_adv;
          cnt_nxt       = cnt_r - 1'b1;
          lines_nxt     = lines_r - CW'(rd_nl && (lines_r != '0));
          out_valid_nxt = 1'b1;
          byte_nxt      = mem_rd_data;
          bvalid_nxt    = 1'b1;
          status_nxt    = ST_OK;
          bheld_nxt     = held_t'(cnt_nxt);
          lheld_nxt     = held_t'(lines_nxt);
          if (state_r == S_POP) begin
            last_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            last_nxt = rd_nl;
            if (rd_nl || (cnt_r == CW'(1))) begin
              state_nxt = S_IDLE;
            end else begin
              // prefetch the next byte while this one goes out
              mem_rd_en   = 1'b1;
              mem_rd_addr = rptr_adv;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rptr_r      <= '0;
      wptr_r      <= '0;
      cnt_r       <= '0;
      lines_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rptr_r      <= rptr_nxt;
      wptr_r      <= wptr_nxt;
      cnt_r       <= cnt_nxt;
      lines_r     <= lines_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    bvalid_r <= bvalid_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
    bheld_r  <= bheld_nxt;
    lheld_r  <= lheld_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_out_byte   = byte_r;
  assign out_byte_valid = bvalid_r;
  assign out_last       = last_r;
  assign out_status     = status_r;
  assign out_bytes_held = bheld_r;
  assign out_lines_held = lheld_r;

endmodule

[sv/line_counting_byte_fifo.sv]
// ----------------------------------------------------------------------------
// line_counting_byte_fifo
// Circular byte FIFO that tracks how many newline bytes it holds.
//
// Input channel (in_valid/in_stall) carries one operation per beat: push
// in_data_byte, pop one byte, or pop a whole line. Result channel
// (out_valid/out_stall) returns one beat per push or pop and one beat per
// removed byte for a line pop, the newline beat flagged by out_last. Error
// and no-line cases give a single status beat.
// Push and error cases: result registered in the cycle after acceptance,
// next operation accepted while it is presented unless out_stall holds it.
// Pop: the byte store's registered read, then the result register. Line
// pop: the registered read first, then one byte per cycle while out_stall
// is low, the read of the next byte overlapping the output of the current
// one; the block takes no new operation until the newline beat is loaded.
// Synchronous active-low reset empties the FIFO and drops any pending beat;
// the byte store itself is not cleared. While a result is pending and
// out_stall is high, the result register holds and no further operation is taken.
// ----------------------------------------------------------------------------
module line_counting_byte_fifo
  import lcbf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  op_t     in_operation,
  input  byte_t   in_data_byte,
  output logic    out_valid,
  input  logic    out_stall,
  output byte_t   out_out_byte,
  output logic    out_byte_valid,
  output logic    out_last,
  output status_t out_status,
  output held_t   out_bytes_held,
  output held_t   out_lines_held
);

  localparam int AW = $clog2(DEPTH);

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  byte_t         mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  byte_t         mem_rd_data;

  lcbf_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  lcbf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_status     (out_status),
    .out_bytes_held (out_bytes_held),
    .out_lines_held (out_lines_held),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  a_lines_le_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lines_held <= out_bytes_held))
    else $error("line count exceeds byte count");

  a_byte_beat_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_valid) |-> (out_status == ST_OK))
    else $error("data beat with error status");

  a_status_beat_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> (out_last && (out_out_byte == '0)))
    else $error("status beat not last or carries data");

  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bytes_held <= held_t'(DEPTH)))
    else $error("byte count above depth");

endmodule
